// ===== sv/bums_pkg.sv =====
package bums_pkg;

    localparam int VALUE_W = 32;
    localparam int EXT_W   = 64;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } t_out_item;

    typedef struct packed {
        logic left_avail;
        logic right_avail;
    } t_merge_ctl;

endpackage

// ===== sv/bums_if.sv =====
interface bums_in_if;
    logic                valid;
    logic                ready;
    bums_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bums_out_if;
    logic                valid;
    logic                ready;
    bums_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/bums_ram.sv =====
module bums_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== sv/bums_merge_unit.sv =====
module bums_merge_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  bums_pkg::t_merge_ctl    i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_left,
    input  logic signed [DATA_WIDTH-1:0] i_right,
    output logic                    o_take_left,
    output logic signed [DATA_WIDTH-1:0] o_value
);

    // left run wins ties
    assign o_take_left = i_ctl.left_avail && (!i_ctl.right_avail || (i_left <= i_right));
    assign o_value     = o_take_left ? i_left : i_right;

endmodule

// ===== sv/bottom_up_merge_sorter_core.sv =====
// Channel  | Dir | Payload                           | Request
// i_in     | in  | value[31:0] signed, last          | one element to store
// o_out    | out | sorted_value[31:0], last_out, ovf | one sorted element
//
// Loading accepts one element per cycle. The sort runs ceil(log2(N)) passes over
// two ping-pong RAMs; each pass handles every element with a registered read
// (S_RD), then a compare and write (S_CMP), plus a setup state (S_PASS) per run
// pair. Each result is read from RAM (S_ORD), then presented (S_OV) until taken.
// i_rst_n is synchronous and clears control state only; RAM contents are not
// cleared. i_in.ready is high only while loading; a stalled result holds.
module bottom_up_merge_sorter_core #(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bums_in_if.sink      i_in,
    bums_out_if.source   o_out
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_ORD  = 3'd4;
    localparam logic [2:0] S_OV   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf,   n_ovf;
    logic          r_src,   n_src;
    logic [CW-1:0] r_w,     n_w;
    logic [CW-1:0] r_base,  n_base;
    logic [CW-1:0] r_i,     n_i;
    logic [CW-1:0] r_i_end, n_i_end;
    logic [CW-1:0] r_j,     n_j;
    logic [CW-1:0] r_j_end, n_j_end;
    logic [CW-1:0] r_k,     n_k;

    logic                         w_in_acc;
    logic                         w_out_acc;
    logic                         w_we_load;
    logic                         w_we_merge;
    logic signed [bums_pkg::EXT_W-1:0] w_in_ext;
    logic signed [bums_pkg::EXT_W-1:0] w_out_ext;
    logic signed [DATA_WIDTH-1:0] w_elem;
    logic [DATA_WIDTH-1:0]        w_ram0_a, w_ram0_b, w_ram1_a, w_ram1_b;
    logic signed [DATA_WIDTH-1:0] w_head_a, w_head_b;
    logic signed [DATA_WIDTH-1:0] w_merged;
    logic                         w_take_left;
    bums_pkg::t_merge_ctl         w_ctl;
    logic [CW+1:0]                w_mid_sum, w_hi_sum, w_n_ext;
    logic [CW-1:0]                w_mid, w_hi;
    logic [CW:0]                  w_w2;
    logic [CW-1:0]                w_k_inc;
    logic                         w_last_out;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    assign w_in_ext = bums_pkg::EXT_W'(i_in.payload.value);
    assign w_elem   = w_in_ext[DATA_WIDTH-1:0];

    assign w_head_a = r_src ? w_ram1_a : w_ram0_a;
    assign w_head_b = r_src ? w_ram1_b : w_ram0_b;

    assign w_ctl.left_avail  = (r_i < r_i_end);
    assign w_ctl.right_avail = (r_j < r_j_end);

    assign w_n_ext   = (CW+2)'(r_count);
    assign w_mid_sum = (CW+2)'(r_base) + (CW+2)'(r_w);
    assign w_hi_sum  = (CW+2)'(r_base) + (CW+2)'({r_w, 1'b0});
    assign w_mid     = (w_mid_sum < w_n_ext) ? w_mid_sum[CW-1:0] : r_count;
    assign w_hi      = (w_hi_sum < w_n_ext) ? w_hi_sum[CW-1:0] : r_count;
    assign w_w2      = {r_w, 1'b0};
    assign w_k_inc   = r_k + CW'(1);

    assign w_last_out = ((CW+1)'(r_i) + (CW+1)'(1)) == (CW+1)'(r_count);

    bums_merge_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .i_ctl       (w_ctl),
        .i_left      (w_head_a),
        .i_right     (w_head_b),
        .o_take_left (w_take_left),
        .o_value     (w_merged)
    );

    bums_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (w_we_load || (w_we_merge && r_src)),
        .i_waddr   (w_we_load ? r_count[AW-1:0] : r_k[AW-1:0]),
        .i_wdata   (w_we_load ? w_elem : w_merged),
        .i_raddr_a (r_i[AW-1:0]),
        .i_raddr_b (r_j[AW-1:0]),
        .o_rdata_a (w_ram0_a),
        .o_rdata_b (w_ram0_b)
    );

    bums_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (w_we_merge && !r_src),
        .i_waddr   (r_k[AW-1:0]),
        .i_wdata   (w_merged),
        .i_raddr_a (r_i[AW-1:0]),
        .i_raddr_b (r_j[AW-1:0]),
        .o_rdata_a (w_ram1_a),
        .o_rdata_b (w_ram1_b)
    );

    assign i_in.ready  = (r_state == S_LOAD);
    assign o_out.valid = (r_state == S_OV);

    assign w_out_ext                  = bums_pkg::EXT_W'(w_head_a);
    assign o_out.payload.sorted_value = w_out_ext[bums_pkg::VALUE_W-1:0];
    assign o_out.payload.last_out     = w_last_out;
    assign o_out.payload.overflow     = r_ovf;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_src      = r_src;
        n_w        = r_w;
        n_base     = r_base;
        n_i        = r_i;
        n_i_end    = r_i_end;
        n_j        = r_j;
        n_j_end    = r_j_end;
        n_k        = r_k;
        w_we_load  = 1'b0;
        w_we_merge = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (r_count < CW'(MAX_ELEMENTS)) begin
                        w_we_load = 1'b1;
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.payload.last) begin
                        n_w    = CW'(1);
                        n_base = '0;
                        n_src  = 1'b0;
                        n_i    = '0;
                        if (n_count < CW'(2)) begin
                            n_state = S_ORD;
                        end else begin
                            n_state = S_PASS;
                        end
                    end
                end
            end
            S_PASS: begin
                n_i     = r_base;
                n_i_end = w_mid;
                n_j     = w_mid;
                n_j_end = w_hi;
                n_k     = r_base;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                w_we_merge = 1'b1;
                n_k        = w_k_inc;
                if (w_take_left) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                if (w_k_inc == r_j_end) begin
                    n_base = r_j_end;
                    if (r_j_end == r_count) begin
                        n_src  = !r_src;
                        n_w    = w_w2[CW-1:0];
                        n_base = '0;
                        if (w_w2 >= (CW+1)'(r_count)) begin
                            n_i     = '0;
                            n_state = S_ORD;
                        end else begin
                            n_state = S_PASS;
                        end
                    end else begin
                        n_state = S_PASS;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_ORD: begin
                n_state = S_OV;
            end
            S_OV: begin
                if (w_out_acc) begin
                    n_i = r_i + CW'(1);
                    if (w_last_out) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_src   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
            r_w     <= '0;
            r_base  <= '0;
            r_i     <= '0;
            r_i_end <= '0;
            r_j     <= '0;
            r_j_end <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
            r_w     <= n_w;
            r_base  <= n_base;
            r_i     <= n_i;
            r_i_end <= n_i_end;
            r_j     <= n_j;
            r_j_end <= n_j_end;
            r_k     <= n_k;
        end
    end

endmodule
